[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the line rasterizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/lpr_pkg.sv]
// ----------------------------------------------------------------------------
// lpr_pkg
// Types and constants shared by the line pixel rasterizer modules.
// ----------------------------------------------------------------------------
package lpr_pkg;

  // Coordinate and datapath widths
  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int ERR_W   = 11;
  localparam int PIX_W   = 19;
  localparam int COLOR_W = 16;

  // Frame buffer line pitch in pixels
  localparam int SCREEN_WIDTH = 800;

  // Front-to-walker queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Register file: paddr width and register select (paddr bit 2)
  localparam int   CFG_AW           = 3;
  localparam int   CFG_DW           = 32;
  localparam logic REG_DRAW_COLOR   = 1'b0;
  localparam logic REG_TARGET_LAYER = 1'b1;

  // Input transfer payload
  typedef struct packed {
    logic             cmd;
    logic [COL_W-1:0] start_x;
    logic [ROW_W-1:0] start_y;
    logic [COL_W-1:0] end_x;
    logic [ROW_W-1:0] end_y;
  } lpr_in_t;

  // Output transfer payload
  typedef struct packed {
    logic [PIX_W-1:0]   pixel_index;
    logic [COLOR_W-1:0] color;
    logic               layer;
    logic               last;
  } lpr_out_t;

  // Classified command passed from front to walker
  typedef struct packed {
    logic             is_start;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] left;
    logic [ERR_W-1:0] err;
    logic [COL_W-1:0] major;
    logic [COL_W-1:0] minor;
    logic             x_major;
    logic             col_neg;
    logic             row_neg;
  } lpr_cmd_t;

endpackage

[rtl/core/lpr_front.sv]
// ----------------------------------------------------------------------------
// lpr_front
// Accepts command transfers and classifies start commands into a walker
// setup record (direction, major axis, deltas, initial error, pixels after the first).
// ----------------------------------------------------------------------------
module lpr_front (
  input  logic             in_valid,
  output logic             in_stall,
  input  lpr_pkg::lpr_in_t in_data,
  input  logic             q_full,
  output logic             q_wr,
  output lpr_pkg::lpr_cmd_t q_wr_data
);

  logic [lpr_pkg::COL_W-1:0] dx;
  logic [lpr_pkg::COL_W-1:0] dy;
  logic                      ex_lt_sx;
  logic                      ey_lt_sy;
  logic                      dx_ge_dy;
  logic [lpr_pkg::COL_W-1:0] major;
  lpr_pkg::lpr_cmd_t         setup;

  // Handshake: stall only on a full queue
  assign in_stall = q_full;
  assign q_wr     = in_valid && !q_full;

  // Absolute deltas and directions
  assign ex_lt_sx = in_data.end_x < in_data.start_x;
  assign ey_lt_sy = in_data.end_y < in_data.start_y;
  assign dx = ex_lt_sx ? (in_data.start_x - in_data.end_x)
                       : (in_data.end_x - in_data.start_x);
  assign dy = ey_lt_sy ? lpr_pkg::COL_W'(in_data.start_y - in_data.end_y)
                       : lpr_pkg::COL_W'(in_data.end_y - in_data.start_y);
  assign dx_ge_dy = dx >= dy;
  assign major    = dx_ge_dy ? dx : dy;

  // Line classification
  always_comb begin
    setup          = '0;
    setup.is_start = 1'b1;
    if (in_data.start_x == in_data.end_x) begin
      // vertical, single point included
      setup.col   = in_data.start_x;
      setup.row   = ey_lt_sy ? in_data.end_y : in_data.start_y;
      setup.major = dy;
      setup.left  = dy;
    end else if (in_data.start_y == in_data.end_y) begin
      // horizontal
      setup.x_major = 1'b1;
      setup.row     = in_data.start_y;
      setup.col     = ex_lt_sx ? in_data.end_x : in_data.start_x;
      setup.major   = dx;
      setup.left    = dx;
    end else begin
      // general Bresenham walk from the start point
      setup.col     = in_data.start_x;
      setup.row     = in_data.start_y;
      setup.col_neg = ex_lt_sx;
      setup.row_neg = ey_lt_sy;
      setup.x_major = dx_ge_dy;
      setup.major   = major;
      setup.minor   = dx_ge_dy ? dy : dx;
      setup.err     = lpr_pkg::ERR_W'(major >> 1);
      setup.left    = major - lpr_pkg::COL_W'(1);
    end
  end

  // Step commands carry no setup
  always_comb begin
    if (in_data.cmd == lpr_pkg::CMD_START) begin
      q_wr_data = setup;
    end else begin
      q_wr_data = '0;
    end
  end

endmodule

[rtl/core/lpr_queue.sv]
// ----------------------------------------------------------------------------
// lpr_queue
// Short FIFO of classified commands between the front and the walker.
// ----------------------------------------------------------------------------
module lpr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  lpr_pkg::lpr_cmd_t wr_data,
  output logic              full,
  input  logic              rd,
  output logic              rd_valid,
  output lpr_pkg::lpr_cmd_t rd_data
);

  lpr_pkg::lpr_cmd_t             mem_r [lpr_pkg::QUEUE_DEPTH];
  logic [lpr_pkg::QUEUE_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [lpr_pkg::QUEUE_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [lpr_pkg::QUEUE_CW-1:0]  count_r, count_nxt;
  logic                          do_wr;
  logic                          do_rd;

  assign full     = count_r == lpr_pkg::QUEUE_CW'(lpr_pkg::QUEUE_DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr && !full;
  assign do_rd    = rd && rd_valid;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[rtl/core/lpr_walk.sv]
// ----------------------------------------------------------------------------
// lpr_walk
// Line walker: loads setup records and performs one Bresenham step per step
// command, driving the registered pixel output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpr_walk (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  lpr_pkg::lpr_cmd_t           q_data,
  output logic                        q_rd,
  input  logic [lpr_pkg::COLOR_W-1:0] draw_color,
  input  logic                        target_layer,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lpr_pkg::lpr_out_t           out_data
);

  logic                      active_r, active_nxt;
  logic [lpr_pkg::COL_W-1:0] col_r, col_nxt;
  logic [lpr_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [lpr_pkg::COL_W-1:0] left_r, left_nxt;
  logic [lpr_pkg::ERR_W-1:0] err_r, err_nxt;
  logic [lpr_pkg::COL_W-1:0] major_r, major_nxt;
  logic [lpr_pkg::COL_W-1:0] minor_r, minor_nxt;
  logic                      x_major_r, x_major_nxt;
  logic                      col_neg_r, col_neg_nxt;
  logic                      row_neg_r, row_neg_nxt;
  logic                      out_valid_r, out_valid_nxt;
  lpr_pkg::lpr_out_t         out_data_r, out_data_nxt;

  logic                      out_free;
  logic                      emit;
  logic                      last;
  logic [lpr_pkg::ERR_W-1:0] err_sum;
  logic                      minor_move;
  logic                      move_col;
  logic                      move_row;
  logic [lpr_pkg::PIX_W-1:0] row_base;
  logic [lpr_pkg::PIX_W-1:0] pix_index;

  // Pop: starts and idle steps never need the output register
  assign out_free = !out_valid_r || !out_stall;
  assign q_rd     = q_valid && (q_data.is_start || !active_r || out_free);
  assign emit     = q_rd && !q_data.is_start && active_r;
  assign last     = left_r == '0;

  // Error update and axis moves
  assign err_sum    = err_r + lpr_pkg::ERR_W'(minor_r);
  assign minor_move = err_sum >= lpr_pkg::ERR_W'(major_r);
  assign move_col   = x_major_r || minor_move;
  assign move_row   = !x_major_r || minor_move;

  // Frame buffer index
  assign row_base  = lpr_pkg::PIX_W'(row_r * lpr_pkg::SCREEN_WIDTH);
  assign pix_index = row_base + lpr_pkg::PIX_W'(col_r);

  // Walker state update
  always_comb begin
    active_nxt  = active_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    left_nxt    = left_r;
    err_nxt     = err_r;
    major_nxt   = major_r;
    minor_nxt   = minor_r;
    x_major_nxt = x_major_r;
    col_neg_nxt = col_neg_r;
    row_neg_nxt = row_neg_r;
    if (q_rd && q_data.is_start) begin
      active_nxt  = 1'b1;
      col_nxt     = q_data.col;
      row_nxt     = q_data.row;
      left_nxt    = q_data.left;
      err_nxt     = q_data.err;
      major_nxt   = q_data.major;
      minor_nxt   = q_data.minor;
      x_major_nxt = q_data.x_major;
      col_neg_nxt = q_data.col_neg;
      row_neg_nxt = q_data.row_neg;
    end else if (emit) begin
      if (last) begin
        active_nxt = 1'b0;
      end else begin
        left_nxt = left_r - 1'b1;
        err_nxt  = minor_move ? err_sum - lpr_pkg::ERR_W'(major_r) : err_sum;
        if (move_col) begin
          col_nxt = col_neg_r ? col_r - 1'b1 : col_r + 1'b1;
        end
        if (move_row) begin
          row_nxt = row_neg_r ? row_r - 1'b1 : row_r + 1'b1;
        end
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.pixel_index = pix_index;
      out_data_nxt.color       = draw_color;
      out_data_nxt.layer       = target_layer;
      out_data_nxt.last        = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      err_r       <= '0;
      major_r     <= '0;
      minor_r     <= '0;
      x_major_r   <= 1'b0;
      col_neg_r   <= 1'b0;
      row_neg_r   <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      left_r      <= left_nxt;
      err_r       <= err_nxt;
      major_r     <= major_nxt;
      minor_r     <= minor_nxt;
      x_major_r   <= x_major_nxt;
      col_neg_r   <= col_neg_nxt;
      row_neg_r   <= row_neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `ASSERT_CLK(a_err_bound, active_r |-> (err_r <= lpr_pkg::ERR_W'(major_r)),
    "error accumulator exceeds major delta")
  `ASSERT_CLK(a_emit_shows, emit |=> out_valid_r,
    "step on an active line did not load the output register")
  `ASSERT_CLK(a_last_ends, (emit && last) |=> !active_r,
    "line still active after its last pixel")

endmodule

[rtl/core/line_pixel_rasterizer.sv]
// ----------------------------------------------------------------------------
// line_pixel_rasterizer
// Bresenham line walker producing one frame buffer pixel write per step.
// ----------------------------------------------------------------------------
// A start command (cmd 0) loads two endpoints and gives no output; each step
// command (cmd 1) then gives the next pixel as col + row * 800 with the draw
// color, the target layer and a last flag. Steps while no line is active are
// dropped, and a start abandons any line in progress. One command is taken
// per cycle unless the queue is full, and one pixel leaves per cycle unless
// out_stall is high; the limit is the single-step update of the walker's
// error and coordinate registers. A step command is written into the
// four-entry command queue at the edge that takes it; the walker pops it once
// the output register is free and loads its pixel there. Registers:
// draw_color at 0x0, target_layer at 0x4; write them only while no line work is pending.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lpr_pkg::lpr_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output lpr_pkg::lpr_out_t          out_data,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [lpr_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [lpr_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [lpr_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic [lpr_pkg::COLOR_W-1:0] draw_color_r, draw_color_nxt;
  logic                        target_layer_r, target_layer_nxt;
  logic                        cfg_wr;
  logic                        q_full;
  logic                        q_wr;
  lpr_pkg::lpr_cmd_t           q_wr_data;
  logic                        q_rd;
  logic                        q_valid;
  lpr_pkg::lpr_cmd_t           q_rd_data;

  // Register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    draw_color_nxt   = draw_color_r;
    target_layer_nxt = target_layer_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        lpr_pkg::REG_DRAW_COLOR: begin
          draw_color_nxt = cfg_pwdata[lpr_pkg::COLOR_W-1:0];
        end
        lpr_pkg::REG_TARGET_LAYER: begin
          target_layer_nxt = cfg_pwdata[0];
        end
        default: begin
          draw_color_nxt = draw_color_r;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      lpr_pkg::REG_DRAW_COLOR: begin
        cfg_prdata = lpr_pkg::CFG_DW'(draw_color_r);
      end
      lpr_pkg::REG_TARGET_LAYER: begin
        cfg_prdata = lpr_pkg::CFG_DW'(target_layer_r);
      end
      default: begin
        cfg_prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_color_r   <= '0;
      target_layer_r <= 1'b0;
    end else begin
      draw_color_r   <= draw_color_nxt;
      target_layer_r <= target_layer_nxt;
    end
  end

  // Command front end
  lpr_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_wr_data (q_wr_data)
  );

  // Command queue
  lpr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .rd       (q_rd),
    .rd_valid (q_valid),
    .rd_data  (q_rd_data)
  );

  // Line walker
  lpr_walk u_walk (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_data       (q_rd_data),
    .q_rd         (q_rd),
    .draw_color   (draw_color_r),
    .target_layer (target_layer_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line pixel rasterizer. A directed table covers
// idle steps, single points, vertical and horizontal lines given backward,
// off-screen coordinates, Bresenham lines and abandoned lines. Random lines
// follow under several color/layer settings. Every pixel transfer is compared
// field by field with a typed-in pixel or one from a line walker in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import lpr_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int TAIL_CYCLES  = 8;
  localparam int PHASE_ITEMS  = 150;
  localparam int NUM_PHASES   = 6;

  // Directed rows: pixel index typed in, nothing expected, or left to the walker
  localparam int USE_WALKER = -2;
  localparam int NO_PIXEL   = -1;

  typedef struct {
    lpr_in_t cmd_item;
    int      want_index;
    bit      want_last;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  lpr_in_t               in_data     = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  lpr_out_t              out_data;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr   = '0;
  logic [CFG_DW-1:0]     cfg_pwdata  = '0;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  // Walker state and register copies
  bit                 ln_active;
  logic [COL_W-1:0]   ln_col;
  logic [ROW_W-1:0]   ln_row;
  logic [COL_W-1:0]   ln_left;
  logic [ERR_W-1:0]   ln_err;
  logic [COL_W-1:0]   ln_major;
  logic [COL_W-1:0]   ln_minor;
  bit                 ln_x_major;
  bit                 ln_col_neg;
  bit                 ln_row_neg;
  logic [COLOR_W-1:0] pen_color;
  bit                 pen_layer;

  lpr_out_t pixel_q[$];
  dir_row_t dir_rows[$];

  int  mismatch_cnt  = 0;
  int  cycle_cnt     = 0;
  int  xfer_cnt      = 0;
  int  start_cnt     = 0;
  int  pixel_cnt     = 0;
  int  line_end_cnt  = 0;
  bit  calm          = 1'b0;

  line_pixel_rasterizer DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long; none while calm
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Walker step for one accepted command; returns 1 when a pixel is due
  function automatic bit rasterize_item(input lpr_in_t d, output lpr_out_t px);
    logic [COL_W-1:0] dx;
    logic [COL_W-1:0] dy;
    int               idx;
    px = '0;
    if (d.cmd == CMD_START) begin
      dx = (d.end_x >= d.start_x) ? d.end_x - d.start_x : d.start_x - d.end_x;
      dy = (d.end_y >= d.start_y) ? COL_W'(d.end_y - d.start_y)
                                  : COL_W'(d.start_y - d.end_y);
      ln_active  = 1'b1;
      ln_err     = '0;
      ln_col_neg = 1'b0;
      ln_row_neg = 1'b0;
      ln_minor   = '0;
      if (d.start_x == d.end_x) begin
        // vertical or single point: walk up from the smaller row
        ln_x_major = 1'b0;
        ln_col     = d.start_x;
        ln_row     = (d.start_y < d.end_y) ? d.start_y : d.end_y;
        ln_major   = dy;
        ln_left    = dy;
      end else if (d.start_y == d.end_y) begin
        ln_x_major = 1'b1;
        ln_row     = d.start_y;
        ln_col     = (d.start_x < d.end_x) ? d.start_x : d.end_x;
        ln_major   = dx;
        ln_left    = dx;
      end else begin
        // general line: end point is not drawn
        ln_col     = d.start_x;
        ln_row     = d.start_y;
        ln_col_neg = d.end_x < d.start_x;
        ln_row_neg = d.end_y < d.start_y;
        ln_x_major = dx >= dy;
        ln_major   = ln_x_major ? dx : dy;
        ln_minor   = ln_x_major ? dy : dx;
        ln_err     = ERR_W'(ln_major >> 1);
        ln_left    = ln_major - 1'b1;
      end
      return 1'b0;
    end
    if (!ln_active) return 1'b0;

    idx            = ln_col + ln_row * SCREEN_WIDTH;
    px.pixel_index = PIX_W'(idx);
    px.color       = pen_color;
    px.layer       = pen_layer;
    px.last        = (ln_left == '0);
    if (px.last) begin
      ln_active = 1'b0;
      return 1'b1;
    end
    ln_left = ln_left - 1'b1;
    ln_err  = ln_err + ln_minor;
    if (ln_err >= ln_major) begin
      ln_err = ln_err - ln_major;
      if (ln_x_major) ln_row = ln_row_neg ? ln_row - 1'b1 : ln_row + 1'b1;
      else            ln_col = ln_col_neg ? ln_col - 1'b1 : ln_col + 1'b1;
    end
    if (ln_x_major) ln_col = ln_col_neg ? ln_col - 1'b1 : ln_col + 1'b1;
    else            ln_row = ln_row_neg ? ln_row - 1'b1 : ln_row + 1'b1;
    return 1'b1;
  endfunction

  // Drive one command and hold it until the transfer completes
  task automatic send_cmd(input lpr_in_t d);
    int  gap;
    bit  took;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    if (d.cmd == CMD_START) start_cnt++;
  endtask

  // Send a command and queue whatever pixel the walker predicts
  task automatic issue(input lpr_in_t d);
    lpr_out_t px;
    bit       has_px;
    send_cmd(d);
    has_px = rasterize_item(d, px);
    if (has_px) pixel_q.push_back(px);
    xfer_cnt++;
  endtask

  // Stop sending, wait for every pixel plus the pipeline tail
  task automatic drain();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // APB write: setup then access, finishes when pready is seen
  task automatic cfg_write(input logic reg_sel, input logic [CFG_DW-1:0] val);
    bit rdy;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = cfg_pready;
      @(posedge clk);
    end while (!rdy);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    // return to idle before the next write
    @(posedge clk);
    if (reg_sel == REG_DRAW_COLOR) pen_color = val[COLOR_W-1:0];
    else                           pen_layer = val[0];
  endtask

  task automatic add_row(input logic cmd, input int sx, input int sy, input int ex,
                         input int ey, input int want_index, input bit want_last);
    dir_row_t r;
    r.cmd_item.cmd     = cmd;
    r.cmd_item.start_x = COL_W'(sx);
    r.cmd_item.start_y = ROW_W'(sy);
    r.cmd_item.end_x   = COL_W'(ex);
    r.cmd_item.end_y   = ROW_W'(ey);
    r.want_index       = want_index;
    r.want_last        = want_last;
    dir_rows.push_back(r);
  endtask

  // One random line: start, then a walk that may stop short or overrun
  task automatic draw_random_line();
    lpr_in_t d;
    int      kind;
    int      sx;
    int      sy;
    int      count;
    int      n_steps;
    kind      = $urandom_range(0, 9);
    sx        = $urandom_range(0, 1023);
    sy        = $urandom_range(0, 511);
    d.cmd     = CMD_START;
    d.start_x = COL_W'(sx);
    d.start_y = ROW_W'(sy);
    d.end_x   = COL_W'($urandom_range(sx < 12 ? 0 : sx - 12, sx > 1011 ? 1023 : sx + 12));
    d.end_y   = ROW_W'($urandom_range(sy < 12 ? 0 : sy - 12, sy > 499 ? 511 : sy + 12));
    case (kind)
      0: d.end_x = d.start_x;
      1: d.end_y = d.start_y;
      2: begin
        d.end_x = d.start_x;
        d.end_y = d.start_y;
      end
      3: begin
        d.end_x = COL_W'($urandom);
        d.end_y = ROW_W'($urandom);
      end
      default: ;
    endcase
    issue(d);
    count = ln_left + 1;
    if (kind == 3)                      n_steps = $urandom_range(1, 24);
    else if ($urandom_range(0, 5) == 0) n_steps = $urandom_range(0, count - 1);
    else                                n_steps = count + $urandom_range(0, 2);
    repeat (n_steps) begin
      // coordinate fields of a step are don't-care, so fill them with noise
      d         = lpr_in_t'({$urandom, $urandom});
      d.cmd     = CMD_STEP;
      issue(d);
    end
  endtask

  // Result side stall pattern
  initial begin
    int n;
    @(posedge clk);
    forever begin
      n = idle_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Pixel checker: a transfer completes at the next rising edge
  always @(negedge clk) begin
    lpr_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        report($sformatf("unexpected pixel transfer, index %0d", out_data.pixel_index));
      end else begin
        want = pixel_q.pop_front();
        pixel_cnt++;
        if (want.last) line_end_cnt++;
        if (out_data.pixel_index !== want.pixel_index)
          report($sformatf("pixel_index got %0d want %0d",
                           out_data.pixel_index, want.pixel_index));
        if (out_data.color !== want.color)
          report($sformatf("color got %h want %h", out_data.color, want.color));
        if (out_data.layer !== want.layer)
          report($sformatf("layer got %b want %b", out_data.layer, want.layer));
        if (out_data.last !== want.last)
          report($sformatf("last got %b want %b (index %0d)",
                           out_data.last, want.last, want.pixel_index));
      end
    end
  end

  // Stimulus
  initial begin
    lpr_out_t px;
    lpr_out_t typed_px;
    bit       has_px;
    int       target;

    ln_active = 1'b0;
    pen_color = '0;
    pen_layer = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // step while idle, then a single point and a step past its end
    add_row(CMD_STEP,  0,   0,   0,   0,   NO_PIXEL,   0);
    add_row(CMD_START, 5,   7,   5,   7,   NO_PIXEL,   0);
    add_row(CMD_STEP,  0,   0,   0,   0,   5605,       1);
    add_row(CMD_STEP,  0,   0,   0,   0,   NO_PIXEL,   0);
    // vertical line given bottom to top, walked from row 0
    add_row(CMD_START, 0,   2,   0,   0,   NO_PIXEL,   0);
    add_row(CMD_STEP,  0,   0,   0,   0,   0,          0);
    add_row(CMD_STEP,  0,   0,   0,   0,   800,        0);
    add_row(CMD_STEP,  0,   0,   0,   0,   1600,       1);
    // horizontal line at the bottom right corner, right to left
    add_row(CMD_START, 799, 479, 797, 479, NO_PIXEL,   0);
    add_row(CMD_STEP,  0,   0,   0,   0,   383997,     0);
    add_row(CMD_STEP,  0,   0,   0,   0,   383998,     0);
    add_row(CMD_STEP,  0,   0,   0,   0,   383999,     1);
    // off-screen point at the field maxima, no clipping
    add_row(CMD_START, 1023, 511, 1023, 511, NO_PIXEL, 0);
    add_row(CMD_STEP,  0,   0,   0,   0,   409823,     1);
    // shallow Bresenham line
    add_row(CMD_START, 0,   0,   3,   1,   NO_PIXEL,   0);
    add_row(CMD_STEP,  0,   0,   0,   0,   USE_WALKER, 0);
    add_row(CMD_STEP,  0,   0,   0,   0,   USE_WALKER, 0);
    add_row(CMD_STEP,  0,   0,   0,   0,   USE_WALKER, 0);
    // long line abandoned after one pixel by a steep line walking backward
    add_row(CMD_START, 800, 0,   0,   479, NO_PIXEL,   0);
    add_row(CMD_STEP,  0,   0,   0,   0,   USE_WALKER, 0);
    add_row(CMD_START, 10,  10,  7,   6,   NO_PIXEL,   0);
    add_row(CMD_STEP,  0,   0,   0,   0,   USE_WALKER, 0);
    add_row(CMD_STEP,  0,   0,   0,   0,   USE_WALKER, 0);
    add_row(CMD_STEP,  0,   0,   0,   0,   USE_WALKER, 0);
    add_row(CMD_STEP,  0,   0,   0,   0,   USE_WALKER, 0);

    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].cmd_item);
      has_px = rasterize_item(dir_rows[i].cmd_item, px);
      if (dir_rows[i].want_index == USE_WALKER) begin
        if (has_px) pixel_q.push_back(px);
      end else if (dir_rows[i].want_index != NO_PIXEL) begin
        typed_px.pixel_index = PIX_W'(dir_rows[i].want_index);
        typed_px.color       = '0;
        typed_px.layer       = 1'b0;
        typed_px.last        = dir_rows[i].want_last;
        pixel_q.push_back(typed_px);
      end
    end

    // Random lines, one register setting per phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          cfg_write(REG_DRAW_COLOR, 32'h0000_FFFF);
          cfg_write(REG_TARGET_LAYER, 32'h1);
        end
        1: begin
          cfg_write(REG_DRAW_COLOR, 32'h0);
          cfg_write(REG_TARGET_LAYER, 32'h0);
        end
        default: begin
          cfg_write(REG_DRAW_COLOR, $urandom);
          cfg_write(REG_TARGET_LAYER, $urandom);
        end
      endcase
      target = xfer_cnt + PHASE_ITEMS;
      while (xfer_cnt < target) begin
        draw_random_line();
        // occasional full pause until every pixel is back
        if ($urandom_range(0, 29) == 0) drain();
        if ($urandom_range(0, 7) == 0)  calm = ~calm;
      end
    end

    drain();
    $display("Covered %0d line starts and %0d random commands over %0d register settings",
             start_cnt, xfer_cnt, NUM_PHASES + 1);
    $display("Checked %0d pixel transfers, %0d of them line ends", pixel_cnt, line_end_cnt);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/lpr_pkg.sv
rtl/core/lpr_front.sv
rtl/core/lpr_queue.sv
rtl/core/lpr_walk.sv
rtl/core/line_pixel_rasterizer.sv
tb/sv/tb_top.sv
